FILE: hw/rtl/pat_pkg.sv
// pat_pkg: shared types and codes for the positional array table
// op and status codes, the per-cell command and the cell control struct
// no dependencies
`timescale 1ns / 1ps

package pat_pkg;

    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_DELETE = 3'd1;
    localparam logic [2:0] OP_SEARCH = 3'd2;
    localparam logic [2:0] OP_READ   = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BADPOS   = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_LOAD_SEARCH,
        CELL_LOAD_READ,
        CELL_SHIFT
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t   cmd;
        logic [31:0] value;
    } cell_ctrl_t;

endpackage

FILE: hw/rtl/pat_in_if.sv
// pat_in_if: request channel of the positional array table
// valid/ready handshake carrying op, value and position; no dependencies
`timescale 1ns / 1ps

interface pat_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         op;
    logic signed [31:0] value;
    logic [7:0]         position;

    modport source (output valid, output op, output value, output position, input ready);
    modport sink   (input valid, input op, input value, input position, output ready);
endinterface

FILE: hw/rtl/pat_out_if.sv
// pat_out_if: result channel of the positional array table
// valid/ready handshake carrying status, index, read data and count; no dependencies
`timescale 1ns / 1ps

interface pat_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [7:0]         found_index;
    logic signed [31:0] read_value;
    logic [8:0]         entry_count;

    modport source (output valid, output status, output found_index, output read_value,
                    output entry_count, input ready);
    modport sink   (input valid, input status, input found_index, input read_value,
                    input entry_count, output ready);
endinterface

FILE: hw/rtl/positional_array_table_top.sv
// positional_array_table_top: packed list of signed words kept in a chain of cells
// depends on pat_pkg, pat_in_if, pat_out_if and pat_cell
`timescale 1ns / 1ps

// usage
//   req carries op, value and position; rsp carries status, found_index,
//   read_value and entry_count, one item per request, in request order
//   insert, delete, clear and unused codes finish without the scan lane;
//   on insert or delete the cells from position upward shift together
//   search and read copy every entry into the scan lane, which then moves
//   one cell toward cell 0 per cycle; read finishes when the entry at
//   position reaches cell 0, search when its lowest match does, or with
//   notfound once the lane passes the last entry (at once if list empty)
//   req.ready is high when no item is in flight, so a new item is taken
//   while the previous result still sits in the rsp register
//   a stalled rsp holds its item; an item whose result is done waits for
//   the register to free, with the cells and the scan lane frozen
//   reset empties the list; entries themselves are not cleared and are
//   only ever read after being written
module positional_array_table_top #(
    parameter int CAPACITY = 256
) (
    input logic      clk,
    input logic      rst_n,
    pat_in_if.sink   req,
    pat_out_if.source rsp
);
    import pat_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = CNT_W + 8;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_WALK} state_t;

    state_t           state_reg;
    logic [2:0]       op_reg;
    logic [31:0]      value_reg;
    logic [7:0]       pos_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] k_reg;
    logic             rsp_valid_reg;
    logic [1:0]       status_reg;
    logic [7:0]       found_reg;
    logic [31:0]      rd_reg;
    logic [8:0]       ecnt_reg;

    cell_ctrl_t       ctrl;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic             slot_free;
    logic             finish;
    logic             go_walk;
    logic [1:0]       res_status;
    logic [7:0]       res_found;
    logic [31:0]      res_rd;
    logic [CNT_W-1:0] cnt_next;
    logic [CNT_W-1:0] k_inc;
    logic [CNT_W+7:0] k_wide;
    logic [CNT_W+8:0] cnt_wide;

    logic [31:0] word_w  [CAPACITY];
    logic [31:0] lane_w  [CAPACITY];
    logic        flag_w  [CAPACITY];
    logic [31:0] below_w [CAPACITY];
    logic [31:0] above_w [CAPACITY];
    logic [31:0] lnab_w  [CAPACITY];
    logic        flab_w  [CAPACITY];

    assign pos_ext   = {{CNT_W{1'b0}}, pos_reg};
    assign cnt_ext   = {8'b0, cnt_reg};
    assign slot_free = !rsp_valid_reg || rsp.ready;
    assign k_inc     = k_reg + CNT_W'(1);
    assign k_wide    = {8'b0, k_reg};
    assign cnt_wide  = {9'b0, cnt_next};

    always_comb
    begin
        ctrl.cmd   = CELL_HOLD;
        ctrl.value = value_reg;
        finish     = 1'b0;
        go_walk    = 1'b0;
        res_status = ST_OK;
        res_found  = 8'b0;
        res_rd     = 32'b0;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            S_EXEC:
            begin
                unique case (op_reg)
                    OP_INSERT:
                    begin
                        finish = 1'b1;
                        if (pos_ext > cnt_ext)
                        begin
                            res_status = ST_BADPOS;
                        end
                        else if (cnt_reg == CAP_CNT)
                        begin
                            res_status = ST_FULL;
                        end
                        else
                        begin
                            cnt_next = cnt_reg + CNT_W'(1);
                            if (slot_free)
                            begin
                                ctrl.cmd = CELL_INSERT;
                            end
                        end
                    end
                    OP_DELETE:
                    begin
                        finish = 1'b1;
                        if (pos_ext >= cnt_ext)
                        begin
                            res_status = ST_BADPOS;
                        end
                        else
                        begin
                            cnt_next = cnt_reg - CNT_W'(1);
                            if (slot_free)
                            begin
                                ctrl.cmd = CELL_DELETE;
                            end
                        end
                    end
                    OP_SEARCH:
                    begin
                        if (cnt_reg == '0)
                        begin
                            finish     = 1'b1;
                            res_status = ST_NOTFOUND;
                        end
                        else
                        begin
                            go_walk  = 1'b1;
                            ctrl.cmd = CELL_LOAD_SEARCH;
                        end
                    end
                    OP_READ:
                    begin
                        if (pos_ext >= cnt_ext)
                        begin
                            finish     = 1'b1;
                            res_status = ST_BADPOS;
                        end
                        else
                        begin
                            go_walk  = 1'b1;
                            ctrl.cmd = CELL_LOAD_READ;
                        end
                    end
                    OP_CLEAR:
                    begin
                        finish   = 1'b1;
                        cnt_next = '0;
                    end
                    default:
                    begin
                        finish = 1'b1;
                    end
                endcase
            end
            S_WALK:
            begin
                if (flag_w[0])
                begin
                    finish = 1'b1;
                    if (op_reg == OP_SEARCH)
                    begin
                        res_found = k_wide[7:0];
                    end
                    else
                    begin
                        res_rd = lane_w[0];
                    end
                end
                else if (k_inc == cnt_reg)
                begin
                    finish     = 1'b1;
                    res_status = ST_NOTFOUND;
                end
                else
                begin
                    ctrl.cmd = CELL_SHIFT;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            k_reg         <= '0;
            rsp_valid_reg <= 1'b0;
            op_reg        <= OP_CLEAR;
            value_reg     <= 32'b0;
            pos_reg       <= 8'b0;
            status_reg    <= ST_OK;
            found_reg     <= 8'b0;
            rd_reg        <= 32'b0;
            ecnt_reg      <= 9'b0;
        end
        else
        begin
            if (finish && slot_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        op_reg    <= req.op;
                        value_reg <= req.value;
                        pos_reg   <= req.position;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC, S_WALK:
                begin
                    if (go_walk)
                    begin
                        k_reg     <= '0;
                        state_reg <= S_WALK;
                    end
                    else if (finish && slot_free)
                    begin
                        status_reg    <= res_status;
                        found_reg     <= res_found;
                        rd_reg        <= res_rd;
                        ecnt_reg      <= cnt_wide[8:0];
                        cnt_reg       <= cnt_next;
                        state_reg     <= S_IDLE;
                    end
                    else if (ctrl.cmd == CELL_SHIFT)
                    begin
                        k_reg <= k_inc;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        if (g == 0)
        begin : g_first
            assign below_w[g] = value_reg;
        end
        else
        begin : g_mid_lo
            assign below_w[g] = word_w[g-1];
        end
        if (g == CAPACITY - 1)
        begin : g_last
            assign above_w[g] = word_w[g];
            assign lnab_w[g]  = 32'b0;
            assign flab_w[g]  = 1'b0;
        end
        else
        begin : g_mid_hi
            assign above_w[g] = word_w[g+1];
            assign lnab_w[g]  = lane_w[g+1];
            assign flab_w[g]  = flag_w[g+1];
        end

        pat_cell #(
            .IDX   (g),
            .CMP_W (CMP_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .pos        (pos_ext),
            .cnt        (cnt_ext),
            .word_below (below_w[g]),
            .word_above (above_w[g]),
            .lane_above (lnab_w[g]),
            .flag_above (flab_w[g]),
            .word       (word_w[g]),
            .lane       (lane_w[g]),
            .flag       (flag_w[g])
        );
    end

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.found_index = found_reg;
    assign rsp.read_value  = rd_reg;
    assign rsp.entry_count = ecnt_reg;

endmodule

FILE: hw/rtl/pat_cell.sv
// pat_cell: one entry of the table plus one stage of the scan lane
// depends on pat_pkg
`timescale 1ns / 1ps

module pat_cell #(
    parameter int IDX   = 0,
    parameter int CMP_W = 17
) (
    input  logic               clk,
    input  logic               rst_n,
    input  pat_pkg::cell_ctrl_t ctrl,
    input  logic [CMP_W-1:0]   pos,
    input  logic [CMP_W-1:0]   cnt,
    input  logic [31:0]        word_below,
    input  logic [31:0]        word_above,
    input  logic [31:0]        lane_above,
    input  logic               flag_above,
    output logic [31:0]        word,
    output logic [31:0]        lane,
    output logic               flag
);
    import pat_pkg::*;

    localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(IDX);

    logic [31:0] word_reg;
    logic [31:0] lane_reg;
    logic        flag_reg;

    always_ff @(posedge clk)
    begin
        unique case (ctrl.cmd)
            CELL_INSERT:
            begin
                if (MY_IDX > pos)
                begin
                    word_reg <= word_below;
                end
                else if (MY_IDX == pos)
                begin
                    word_reg <= ctrl.value;
                end
            end
            CELL_DELETE:
            begin
                if (MY_IDX >= pos)
                begin
                    word_reg <= word_above;
                end
            end
            CELL_LOAD_SEARCH, CELL_LOAD_READ:
            begin
                lane_reg <= word_reg;
            end
            CELL_SHIFT:
            begin
                lane_reg <= lane_above;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg <= 1'b0;
        end
        else
        begin
            unique case (ctrl.cmd)
                CELL_LOAD_SEARCH: flag_reg <= (word_reg == ctrl.value) && (MY_IDX < cnt);
                CELL_LOAD_READ:   flag_reg <= (MY_IDX == pos);
                CELL_SHIFT:       flag_reg <= flag_above;
                default:          flag_reg <= flag_reg;
            endcase
        end
    end

    assign word = word_reg;
    assign lane = lane_reg;
    assign flag = flag_reg;

endmodule

FILE: hw/rtl/pat_checker.sv
// pat_checker: port-level checks for positional_array_table_top
// depends on pat_pkg; bound to the top level below
`timescale 1ns / 1ps

module pat_checker #(
    parameter int CAPACITY = 256
) (
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [1:0]  rsp_status,
    input logic [7:0]  rsp_found_index,
    input logic [31:0] rsp_read_value,
    input logic [8:0]  rsp_entry_count
);
    import pat_pkg::*;

    localparam logic [8:0] CAP9 = 9'(CAPACITY);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("rsp item dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_status) && $stable(rsp_read_value)
            && $stable(rsp_found_index) && $stable(rsp_entry_count))
        else $error("rsp payload changed while stalled");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == ST_FULL |-> rsp_entry_count == CAP9)
        else $error("list full reported below capacity");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != ST_OK |-> rsp_read_value == 32'b0
            && rsp_found_index == 8'b0)
        else $error("failed item carries data");

endmodule

bind positional_array_table_top pat_checker #(
    .CAPACITY (CAPACITY)
) u_pat_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_found_index (rsp.found_index),
    .rsp_read_value  (rsp.read_value),
    .rsp_entry_count (rsp.entry_count)
);
